### sv/imu_offset_calibrate_compensate_unit_assert.svh
// ----------------------------------------------------------------------------
// IMU offset calibration unit - assertion macros
// Concurrent assertion shorthands that share clock, reset and report style.
// ----------------------------------------------------------------------------
`ifndef IMU_OFFSET_CALIBRATE_COMPENSATE_UNIT_ASSERT_SVH
`define IMU_OFFSET_CALIBRATE_COMPENSATE_UNIT_ASSERT_SVH

// same-cycle implication
`define IMUOCC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMUOCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/imuocc_pkg.sv
// ----------------------------------------------------------------------------
// IMU offset calibration unit - package
// Widths, register defaults, register indexes and shared types.
// ----------------------------------------------------------------------------
package imuocc_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int COUNT_WIDTH     = 16;
  localparam int CALIB_WIDTH     = 16;
  localparam int ALPHA_WIDTH     = 17;
  localparam int GRAVITY_WIDTH   = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 17;
  localparam int FRAC_BITS       = 16;
  localparam int HALF_Q16        = 32768;

  localparam logic [CALIB_WIDTH-1:0]          CALIB_SAMPLES_RESET = 16'd1000;
  localparam logic [ALPHA_WIDTH-1:0]          ALPHA_ONE           = 17'd65536;
  localparam logic [ALPHA_WIDTH-1:0]          ALPHA_RESET         = 17'd65536;
  localparam logic signed [GRAVITY_WIDTH-1:0] GRAVITY_RESET       = 16'sd2511;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_CALIB_SAMPLES    = 2'd0,
    CFG_DC_BLOCKER_ALPHA = 2'd1,
    CFG_GRAVITY_VALUE    = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_MIX_ALPHA,
    ST_MIX_BETA,
    ST_MIX_SUM,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### sv/imuocc_sample_if.sv
// ----------------------------------------------------------------------------
// IMU offset calibration unit - sample channel
// One raw IMU word: three accelerometer axes, three gyro axes, start flag.
// ----------------------------------------------------------------------------
interface imuocc_sample_if #(
  parameter int W = imuocc_pkg::SAMPLE_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] acc_x;
  logic signed [W-1:0] acc_y;
  logic signed [W-1:0] acc_z;
  logic signed [W-1:0] gyro_x;
  logic signed [W-1:0] gyro_y;
  logic signed [W-1:0] gyro_z;
  logic                start_calibration;

  modport source (
    output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, start_calibration,
    input  ready
  );
  modport sink (
    input  valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, start_calibration,
    output ready
  );
endinterface

### sv/imuocc_result_if.sv
// ----------------------------------------------------------------------------
// IMU offset calibration unit - result channel
// One corrected IMU word with calibration status flags.
// ----------------------------------------------------------------------------
interface imuocc_result_if #(
  parameter int W = imuocc_pkg::SAMPLE_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] acc_x_corrected;
  logic signed [W-1:0] acc_y_corrected;
  logic signed [W-1:0] acc_z_corrected;
  logic signed [W-1:0] gyro_x_corrected;
  logic signed [W-1:0] gyro_y_corrected;
  logic signed [W-1:0] gyro_z_corrected;
  logic                calibrating;
  logic                calibration_done;

  modport source (
    output valid, acc_x_corrected, acc_y_corrected, acc_z_corrected,
           gyro_x_corrected, gyro_y_corrected, gyro_z_corrected,
           calibrating, calibration_done,
    input  ready
  );
  modport sink (
    input  valid, acc_x_corrected, acc_y_corrected, acc_z_corrected,
           gyro_x_corrected, gyro_y_corrected, gyro_z_corrected,
           calibrating, calibration_done,
    output ready
  );
endinterface

### sv/imuocc_cfg_if.sv
// ----------------------------------------------------------------------------
// IMU offset calibration unit - configuration channel
// Register write words: register index and write data.
// ----------------------------------------------------------------------------
interface imuocc_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [imuocc_pkg::CFG_INDEX_WIDTH-1:0]   index;
  logic [imuocc_pkg::CFG_DATA_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/imu_offset_calibrate_compensate_unit.sv
// ----------------------------------------------------------------------------
// IMU offset calibration and compensation unit
// Takes one word at a time; the next waits until its result is registered.
// The gyro DC blocker adds mix steps; a run's last word uses the shared
// serial divider for each axis. Synchronous reset restores register defaults.
// ----------------------------------------------------------------------------
module imu_offset_calibrate_compensate_unit #(
  parameter int SAMPLE_WIDTH = imuocc_pkg::SAMPLE_WIDTH,
  parameter int COUNT_WIDTH  = imuocc_pkg::COUNT_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  imuocc_sample_if.sink   sample,
  imuocc_result_if.source result,
  imuocc_cfg_if.sink      cfg
);

  localparam int SW           = SAMPLE_WIDTH;
  localparam int CW           = COUNT_WIDTH;
  localparam int FRAC         = imuocc_pkg::FRAC_BITS;
  localparam int AW           = imuocc_pkg::ALPHA_WIDTH;
  localparam int GW           = imuocc_pkg::GRAVITY_WIDTH;
  localparam int SUM_WIDTH    = SW + CW + 1;
  localparam int DVD_WIDTH    = SUM_WIDTH + FRAC;
  localparam int QUO_WIDTH    = SW + FRAC;
  localparam int OFS_WIDTH    = SW + FRAC;
  localparam int AOFS_WIDTH   = ((SW > GW) ? SW : GW) + 2;
  localparam int ADIFF_WIDTH  = AOFS_WIDTH + 1;
  localparam int GDIFF_WIDTH  = OFS_WIDTH + 2;
  localparam int PROD_WIDTH   = OFS_WIDTH + AW + 1;
  localparam int MIX_WIDTH    = PROD_WIDTH - FRAC;
  localparam int AXES         = 6;
  localparam int GYRO_BASE    = 3;
  localparam int AXIS_WIDTH   = $clog2(AXES);
  localparam int GIDX_WIDTH   = $clog2(GYRO_BASE);

  localparam logic [AXIS_WIDTH-1:0] LAST_AXIS   = AXIS_WIDTH'(AXES - 1);
  localparam logic [AXIS_WIDTH-1:0] LAST_GYRO   = AXIS_WIDTH'(GYRO_BASE - 1);
  localparam logic [AXIS_WIDTH-1:0] FIRST_GYRO  = AXIS_WIDTH'(GYRO_BASE);
  localparam logic [AXIS_WIDTH-1:0] AXIS_ACC_Z  = AXIS_WIDTH'(2);
  localparam logic [CW-1:0]         COUNT_ONE   = CW'(1);

  localparam logic signed [SW-1:0]          SAT_HI = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]          SAT_LO = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [PROD_WIDTH-1:0]  PHALF  = PROD_WIDTH'(imuocc_pkg::HALF_Q16);
  localparam logic signed [GDIFF_WIDTH-1:0] GHALF  = GDIFF_WIDTH'(imuocc_pkg::HALF_Q16);

  imuocc_pkg::state_t state, state_next;
  logic [AXIS_WIDTH-1:0] axis, axis_next;

  logic [imuocc_pkg::CALIB_WIDTH-1:0] calib_samples;
  logic [AW-1:0]                      alpha;
  logic signed [GW-1:0]               gravity;

  logic signed [SW-1:0]         smp [AXES];
  logic                         start_flag;
  logic                         done_flag;
  logic [CW-1:0]                samples_left;
  logic [CW-1:0]                run_count;
  logic signed [SUM_WIDTH-1:0]  sums [AXES];
  logic signed [AOFS_WIDTH-1:0] acc_ofs [GYRO_BASE];
  logic signed [OFS_WIDTH-1:0]  gyro_ofs [GYRO_BASE];
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [MIX_WIDTH-1:0]  part;
  logic                         div_neg;

  logic [CW-1:0]               count_cfg;
  logic                        start_ok;
  logic [CW-1:0]               left_eff;
  logic                        active;
  logic                        run_end;
  logic                        blocker_on;
  logic [AW-1:0]               beta;

  logic signed [SUM_WIDTH-1:0] sum_sel;
  logic                        sum_neg;
  logic [SUM_WIDTH-1:0]        sum_mag;
  logic [DVD_WIDTH-1:0]        dividend;
  logic                        div_start;
  logic [QUO_WIDTH-1:0]        div_quotient;
  imuocc_pkg::div_status_t     div_status;
  logic signed [QUO_WIDTH:0]   quo_signed;
  logic [GIDX_WIDTH-1:0]       div_gidx;
  logic [AXIS_WIDTH-1:0]       gyro_sel;

  logic signed [OFS_WIDTH-1:0]  mul_a;
  logic [AW-1:0]                mul_b;
  logic signed [PROD_WIDTH-1:0] mul_prod;

  logic signed [ADIFF_WIDTH-1:0] acc_diff [GYRO_BASE];
  logic signed [GDIFF_WIDTH-1:0] gyro_diff [GYRO_BASE];
  logic signed [GDIFF_WIDTH-1:0] gyro_sum [GYRO_BASE];
  logic signed [SW-1:0]          acc_corr [GYRO_BASE];
  logic signed [SW-1:0]          gyro_corr [GYRO_BASE];

  imuocc_divider #(
    .DIVIDEND_WIDTH (DVD_WIDTH),
    .QUOTIENT_WIDTH (QUO_WIDTH),
    .DIVISOR_WIDTH  (CW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (run_count),
    .quotient (div_quotient),
    .status   (div_status)
  );

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == imuocc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_samples <= imuocc_pkg::CALIB_SAMPLES_RESET;
      alpha         <= imuocc_pkg::ALPHA_RESET;
      gravity       <= imuocc_pkg::GRAVITY_RESET;
    end else if (cfg.valid) begin
      unique case (imuocc_pkg::cfg_index_t'(cfg.index))
        imuocc_pkg::CFG_CALIB_SAMPLES:    calib_samples <= cfg.data[imuocc_pkg::CALIB_WIDTH-1:0];
        imuocc_pkg::CFG_DC_BLOCKER_ALPHA: alpha <= cfg.data[AW-1:0];
        imuocc_pkg::CFG_GRAVITY_VALUE:    gravity <= cfg.data[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_cfg  = CW'(calib_samples);
    start_ok   = start_flag && (count_cfg != '0);
    left_eff   = start_ok ? count_cfg : samples_left;
    active     = (left_eff != '0);
    run_end    = (left_eff == COUNT_ONE);
    blocker_on = (alpha < imuocc_pkg::ALPHA_ONE);
    beta       = imuocc_pkg::ALPHA_ONE - alpha;

    sum_sel  = sums[axis];
    sum_neg  = sum_sel[SUM_WIDTH-1];
    sum_mag  = sum_neg ? -sum_sel : sum_sel;
    dividend = (axis >= FIRST_GYRO) ? {sum_mag, {FRAC{1'b0}}} : DVD_WIDTH'(sum_mag);
    quo_signed = div_neg ? -$signed({1'b0, div_quotient}) : $signed({1'b0, div_quotient});
    div_gidx   = GIDX_WIDTH'(axis - FIRST_GYRO);
    gyro_sel   = axis + FIRST_GYRO;

    mul_a    = (state == imuocc_pkg::ST_MIX_ALPHA) ? gyro_ofs[axis[GIDX_WIDTH-1:0]]
                                                   : OFS_WIDTH'(smp[gyro_sel]);
    mul_b    = (state == imuocc_pkg::ST_MIX_ALPHA) ? alpha : beta;
    mul_prod = PROD_WIDTH'(mul_a) * PROD_WIDTH'($signed({1'b0, mul_b}));
  end

  always_comb begin
    for (int i = 0; i < GYRO_BASE; i++) begin
      acc_diff[i]  = ADIFF_WIDTH'(smp[i]) - ADIFF_WIDTH'(acc_ofs[i]);
      gyro_diff[i] = GHALF - GDIFF_WIDTH'(gyro_ofs[i]);
      gyro_sum[i]  = GDIFF_WIDTH'(smp[GYRO_BASE + i]) + (gyro_diff[i] >>> FRAC);
      if (acc_diff[i] > ADIFF_WIDTH'(SAT_HI)) begin
        acc_corr[i] = SAT_HI;
      end else if (acc_diff[i] < ADIFF_WIDTH'(SAT_LO)) begin
        acc_corr[i] = SAT_LO;
      end else begin
        acc_corr[i] = acc_diff[i][SW-1:0];
      end
      if (gyro_sum[i] > GDIFF_WIDTH'(SAT_HI)) begin
        gyro_corr[i] = SAT_HI;
      end else if (gyro_sum[i] < GDIFF_WIDTH'(SAT_LO)) begin
        gyro_corr[i] = SAT_LO;
      end else begin
        gyro_corr[i] = gyro_sum[i][SW-1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    div_start  = 1'b0;
    unique case (state)
      imuocc_pkg::ST_IDLE: begin
        if (sample.valid) state_next = imuocc_pkg::ST_ACCUM;
      end
      imuocc_pkg::ST_ACCUM: begin
        axis_next = '0;
        if (active && run_end) begin
          state_next = imuocc_pkg::ST_DIV_LOAD;
        end else if (blocker_on) begin
          state_next = imuocc_pkg::ST_MIX_ALPHA;
        end else begin
          state_next = imuocc_pkg::ST_RESULT;
        end
      end
      imuocc_pkg::ST_DIV_LOAD: begin
        if (!div_status.busy) begin
          div_start  = 1'b1;
          state_next = imuocc_pkg::ST_DIV_WAIT;
        end
      end
      imuocc_pkg::ST_DIV_WAIT: begin
        if (div_status.done) begin
          if (axis == LAST_AXIS) begin
            axis_next  = '0;
            state_next = blocker_on ? imuocc_pkg::ST_MIX_ALPHA : imuocc_pkg::ST_RESULT;
          end else begin
            axis_next  = axis + AXIS_WIDTH'(1);
            state_next = imuocc_pkg::ST_DIV_LOAD;
          end
        end
      end
      imuocc_pkg::ST_MIX_ALPHA: state_next = imuocc_pkg::ST_MIX_BETA;
      imuocc_pkg::ST_MIX_BETA:  state_next = imuocc_pkg::ST_MIX_SUM;
      imuocc_pkg::ST_MIX_SUM: begin
        if (axis == LAST_GYRO) begin
          axis_next  = '0;
          state_next = imuocc_pkg::ST_RESULT;
        end else begin
          axis_next  = axis + AXIS_WIDTH'(1);
          state_next = imuocc_pkg::ST_MIX_ALPHA;
        end
      end
      imuocc_pkg::ST_RESULT: begin
        if (!result.valid || result.ready) state_next = imuocc_pkg::ST_IDLE;
      end
      default: state_next = imuocc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imuocc_pkg::ST_IDLE;
      axis  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_left <= '0;
      run_count    <= '0;
      done_flag    <= 1'b0;
      for (int i = 0; i < AXES; i++) sums[i] <= '0;
      for (int i = 0; i < GYRO_BASE; i++) begin
        acc_ofs[i]  <= '0;
        gyro_ofs[i] <= '0;
      end
    end else begin
      unique case (state)
        imuocc_pkg::ST_ACCUM: begin
          done_flag <= active && run_end;
          if (start_ok) run_count <= count_cfg;
          if (active) begin
            samples_left <= left_eff - COUNT_ONE;
            for (int i = 0; i < AXES; i++) begin
              sums[i] <= (start_ok ? '0 : sums[i]) + SUM_WIDTH'(smp[i]);
            end
          end
        end
        imuocc_pkg::ST_DIV_WAIT: begin
          if (div_status.done) begin
            sums[axis] <= '0;
            if (axis >= FIRST_GYRO) begin
              gyro_ofs[div_gidx] <= OFS_WIDTH'(quo_signed);
            end else begin
              acc_ofs[axis[GIDX_WIDTH-1:0]] <= AOFS_WIDTH'(quo_signed)
                - ((axis == AXIS_ACC_Z) ? AOFS_WIDTH'(gravity) : '0);
            end
          end
        end
        imuocc_pkg::ST_MIX_SUM: begin
          gyro_ofs[axis[GIDX_WIDTH-1:0]] <= OFS_WIDTH'(PROD_WIDTH'(part) + prod);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == imuocc_pkg::ST_IDLE && sample.valid) begin
      smp[0]     <= sample.acc_x;
      smp[1]     <= sample.acc_y;
      smp[2]     <= sample.acc_z;
      smp[3]     <= sample.gyro_x;
      smp[4]     <= sample.gyro_y;
      smp[5]     <= sample.gyro_z;
      start_flag <= sample.start_calibration;
    end
    if (state == imuocc_pkg::ST_DIV_LOAD && !div_status.busy) div_neg <= sum_neg;
    if (state == imuocc_pkg::ST_MIX_ALPHA) prod <= mul_prod;
    if (state == imuocc_pkg::ST_MIX_BETA) begin
      part <= MIX_WIDTH'((prod + PHALF) >>> FRAC);
      prod <= mul_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == imuocc_pkg::ST_RESULT && (!result.valid || result.ready)) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == imuocc_pkg::ST_RESULT && (!result.valid || result.ready)) begin
      result.acc_x_corrected  <= acc_corr[0];
      result.acc_y_corrected  <= acc_corr[1];
      result.acc_z_corrected  <= acc_corr[2];
      result.gyro_x_corrected <= gyro_corr[0];
      result.gyro_y_corrected <= gyro_corr[1];
      result.gyro_z_corrected <= gyro_corr[2];
      result.calibrating      <= (samples_left != '0);
      result.calibration_done <= done_flag;
    end
  end

endmodule

### sv/imuocc_divider.sv
// ----------------------------------------------------------------------------
// IMU offset calibration unit - serial divider
// Restoring unsigned divider, one quotient bit per cycle. The quotient must
// fit QUOTIENT_WIDTH bits.
// ----------------------------------------------------------------------------
module imuocc_divider #(
  parameter int DIVIDEND_WIDTH = 49,
  parameter int QUOTIENT_WIDTH = 32,
  parameter int DIVISOR_WIDTH  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DIVIDEND_WIDTH-1:0]   dividend,
  input  logic [DIVISOR_WIDTH-1:0]    divisor,
  output logic [QUOTIENT_WIDTH-1:0]   quotient,
  output imuocc_pkg::div_status_t     status
);

  localparam int STEP_WIDTH = $clog2(QUOTIENT_WIDTH);
  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(QUOTIENT_WIDTH - 1);

  logic [DIVISOR_WIDTH-1:0]  rem;
  logic [DIVISOR_WIDTH-1:0]  den;
  logic [QUOTIENT_WIDTH-1:0] quo;
  logic [STEP_WIDTH-1:0]     step;
  logic                      busy;
  logic                      done;
  logic [DIVISOR_WIDTH:0]    trial;
  logic [DIVISOR_WIDTH:0]    diff;
  logic                      fits;

  always_comb begin
    trial = {rem, quo[QUOTIENT_WIDTH-1]};
    diff  = trial - {1'b0, den};
    fits  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_WIDTH'(1);
      if (step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[QUOTIENT_WIDTH +: DIVISOR_WIDTH];
      quo <= dividend[QUOTIENT_WIDTH-1:0];
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
      quo <= {quo[QUOTIENT_WIDTH-2:0], fits};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### sv/imuocc_checker.sv
// ----------------------------------------------------------------------------
// IMU offset calibration unit - port checker
// Watches the sample and result ports of the top level and flags rule breaks.
// ----------------------------------------------------------------------------
`include "imu_offset_calibrate_compensate_unit_assert.svh"

module imuocc_checker #(
  parameter int SAMPLE_WIDTH = imuocc_pkg::SAMPLE_WIDTH
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_acc_x,
  input logic [SAMPLE_WIDTH-1:0] out_gyro_z,
  input logic                    out_calibrating,
  input logic                    out_calibration_done
);

  logic [2*SAMPLE_WIDTH+1:0] out_word;
  logic                      in_take;
  logic                      out_stall;

  assign out_word  = {out_acc_x, out_gyro_z, out_calibrating, out_calibration_done};
  assign in_take   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  `IMUOCC_ASSERT_NEXT(a_busy_after_take, clk, rst, in_take, !in_ready, "input ready right after a word was taken")
  `IMUOCC_ASSERT_NEXT(a_no_early_result, clk, rst, in_take && !out_stall, !out_valid, "result word shown one cycle after its input")
  `IMUOCC_ASSERT_SAME(a_done_ends_run, clk, rst, out_valid && out_calibration_done, !out_calibrating, "run end flagged while still calibrating")
  `IMUOCC_ASSERT_NEXT(a_hold_result, clk, rst, out_stall, out_valid && $stable(out_word), "stalled result word changed")

endmodule

bind imu_offset_calibrate_compensate_unit imuocc_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_checker (
  .clk                  (clk),
  .rst                  (rst),
  .in_valid             (sample.valid),
  .in_ready             (sample.ready),
  .out_valid            (result.valid),
  .out_ready            (result.ready),
  .out_acc_x            (result.acc_x_corrected),
  .out_gyro_z           (result.gyro_z_corrected),
  .out_calibrating      (result.calibrating),
  .out_calibration_done (result.calibration_done)
);
